// File: src/hss_pkg.sv
// Shared types and constants for the hashrate share statistics core.
package hss_pkg;

    typedef enum logic [2:0] {
        OP_ADD_HASH = 3'd0,
        OP_ACCEPT   = 3'd1,
        OP_REJECT   = 3'd2,
        OP_BLOCK    = 3'd3,
        OP_TICK     = 3'd4
    } t_op;

    localparam logic [1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_BEST_SEED    = 2'd1;
    localparam logic [1:0] CFG_BLOCKS_SEED  = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] hash_count;
        logic [47:0] difficulty;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [47:0] hash_total;
        logic [39:0] rate_now;
        logic [39:0] rate_minute;
        logic [31:0] shares_accepted;
        logic [31:0] shares_rejected;
        logic [31:0] blocks_found;
        logic [47:0] session_best;
        logic [47:0] overall_best;
        logic [31:0] last_share_ms;
        logic        rate_updated;
    } t_out_word;

    // classified command passed from front to back
    typedef struct packed {
        logic        is_add;
        logic        is_accept;
        logic        is_reject;
        logic        is_block;
        logic        is_tick;
        logic [31:0] hash_count;
        logic [47:0] difficulty;
        logic [31:0] now_ms;
    } t_cmd;

endpackage

// File: src/hashrate_share_statistics_core.sv
// Top level of the hashrate share statistics core.
//
//  channel | signals                              | word
//  --------+--------------------------------------+-----------------
//  input   | i_valid / o_ready / i_word           | t_in_word
//  output  | o_valid / i_ready / o_word           | t_out_word
//  config  | i_cfg_we / i_cfg_index / i_cfg_data  | 48-bit data
//
// Plain ops update the counters and go to the output state; a rate-updating
// tick first runs the one-bit-a-cycle rate divider (66 steps), then the ring
// update and a reciprocal multiply for the minute average.
// After reset a clearing pass zeroes the ring entry by entry; only the
// two queue entries are taken meanwhile. A two-entry queue lets input continue
// while the back end is busy or the output is stalled.
module hashrate_share_statistics_core #(
    parameter int RING_DEPTH = 60
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hss_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output hss_pkg::t_out_word o_word,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);
    logic [15:0] r_min_interval;
    logic [47:0] r_best_seed;
    logic [31:0] r_blocks_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= 16'd100;
            r_best_seed    <= '0;
            r_blocks_seed  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hss_pkg::CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data[15:0];
                hss_pkg::CFG_BEST_SEED:    r_best_seed    <= i_cfg_data;
                hss_pkg::CFG_BLOCKS_SEED:  r_blocks_seed  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic          cmd_valid, cmd_ready;
    hss_pkg::t_cmd cmd;

    hss_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_word,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    hss_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .i_min_interval(r_min_interval), .i_best_seed(r_best_seed),
        .i_blocks_seed(r_blocks_seed),
        .o_valid, .i_ready, .o_word
    );
endmodule

// File: src/hss_front.sv
// Front end: accepts input words, decodes the op and queues commands.
module hss_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hss_pkg::t_in_word i_word,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output hss_pkg::t_cmd     o_cmd
);
    hss_pkg::t_cmd r_q [hss_pkg::QUEUE_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    hss_pkg::t_cmd n_cmd;
    logic          push, pop;

    always_comb begin
        n_cmd            = '0;
        n_cmd.is_add     = (i_word.op == hss_pkg::OP_ADD_HASH);
        n_cmd.is_accept  = (i_word.op == hss_pkg::OP_ACCEPT);
        n_cmd.is_reject  = (i_word.op == hss_pkg::OP_REJECT);
        n_cmd.is_block   = (i_word.op == hss_pkg::OP_BLOCK);
        n_cmd.is_tick    = (i_word.op == hss_pkg::OP_TICK);
        n_cmd.hash_count = i_word.hash_count;
        n_cmd.difficulty = i_word.difficulty;
        n_cmd.now_ms     = i_word.now_ms;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: src/hss_div.sv
// Restoring divider, one quotient bit per cycle.
module hss_div #(
    parameter int NW = 66,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   trial;

    assign trial  = {r_rem[DW-1:0], r_q[NW-1]};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= trial - {1'b0, r_den};
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: src/hss_back.sv
// Back end: statistics state, rate sample ring and result register.
module hss_back #(
    parameter int RING_DEPTH = 60
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  hss_pkg::t_cmd      i_cmd,
    input  logic [15:0]        i_min_interval,
    input  logic [47:0]        i_best_seed,
    input  logic [31:0]        i_blocks_seed,
    output logic               o_valid,
    input  logic               i_ready,
    output hss_pkg::t_out_word o_word
);
    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int TW = 40 + $clog2(RING_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);
    // minute average by reciprocal multiply, 16 bits of the total per cycle
    localparam int LW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int NCH = (TW + 15) / 16;
    localparam int XW  = 16 * NCH;
    localparam int KW  = TW + 2;
    localparam int PRW = XW + KW;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << (TW + LW)) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [KW-1:0] RECIP = RECIP64[KW-1:0];

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_DIV, S_RING_RD, S_RING_WR, S_AVG, S_MUL, S_MEAN, S_OUT
    } t_state;

    t_state        r_state;
    logic [39:0]   r_ring [RING_DEPTH];
    logic [39:0]   r_old;
    logic [PW-1:0] r_pos;
    logic [TW-1:0] r_total;
    logic [47:0]   r_accum, r_at_tick, r_best;
    logic [31:0]   r_tick_time, r_acc, r_rej, r_blk, r_stamp;
    logic          r_armed, r_upd;
    logic [39:0]   r_rate, r_sample, r_minute;
    logic [PW-1:0] r_clr;
    logic [XW-1:0]  r_x;
    logic [PRW-1:0] r_prod;
    logic [2:0]     r_mcnt;
    logic [KW+15:0] part;

    // divider for the rate
    logic          div_start, div_done;
    logic [65:0]   div_num, div_quot;
    logic [31:0]   div_den;
    logic [65:0]   r_num;
    logic [31:0]   r_den;

    hss_div #(.NW(66), .DW(32)) u_div (
        .i_clk, .i_rst_n,
        .i_start(div_start), .i_num(div_num), .i_den(div_den),
        .o_done(div_done), .o_quot(div_quot)
    );
    assign div_num = r_num;
    assign div_den = r_den;

    logic [31:0] elapsed;
    logic [15:0] least;
    logic [47:0] delta;
    logic [65:0] scaled;
    assign elapsed = i_cmd.now_ms - r_tick_time;
    assign least   = (i_min_interval == 16'd0) ? 16'd1 : i_min_interval;
    assign delta   = r_accum - r_at_tick;
    // delta*1000*256 = delta*256000 = (delta<<18)-(delta<<12)-(delta<<11), use constant multiply
    assign scaled  = 66'(delta) * 66'd256000;
    assign part    = RECIP * r_x[XW-1 -: 16];

    assign o_cmd_ready = (r_state == S_IDLE);
    logic take;
    assign take = i_cmd_valid && o_cmd_ready;
    logic r_start;
    assign div_start = r_start;

    always_ff @(posedge i_clk) begin
        if (r_state == S_RING_RD) r_old <= r_ring[r_pos];
        if (r_state == S_RING_WR) r_ring[r_pos] <= r_sample;
        if (r_state == S_CLEAR) r_ring[r_clr] <= '0;
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_start <= 1'b0;
            r_pos <= '0; r_total <= '0; r_accum <= '0; r_at_tick <= '0;
            r_best <= '0; r_tick_time <= '0; r_acc <= '0; r_rej <= '0;
            r_blk <= '0; r_stamp <= '0; r_armed <= 1'b0; r_upd <= 1'b0;
            r_rate <= '0; r_minute <= '0; o_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (o_valid && i_ready && r_state != S_OUT) o_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (take) begin
                        r_upd   <= 1'b0;
                        r_state <= S_OUT;
                        if (i_cmd.is_add) r_accum <= r_accum + 48'(i_cmd.hash_count);
                        if (i_cmd.is_accept) begin
                            r_acc   <= r_acc + 1'b1;
                            r_stamp <= i_cmd.now_ms;
                            if (i_cmd.difficulty > r_best) r_best <= i_cmd.difficulty;
                        end
                        if (i_cmd.is_reject) r_rej <= r_rej + 1'b1;
                        if (i_cmd.is_block) r_blk <= r_blk + 1'b1;
                        if (i_cmd.is_tick) begin
                            if (!r_armed) begin
                                r_armed <= 1'b1; r_tick_time <= i_cmd.now_ms;
                                r_at_tick <= r_accum;
                            end else if (elapsed >= 32'(least)) begin
                                r_tick_time <= i_cmd.now_ms; r_at_tick <= r_accum;
                                r_num <= scaled; r_den <= elapsed;
                                r_start <= 1'b1;
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_sample <= (div_quot[65:40] != '0) ? '1 : div_quot[39:0];
                        r_state  <= S_RING_RD;
                    end
                end
                S_RING_RD: r_state <= S_RING_WR;
                S_RING_WR: begin
                    r_rate  <= r_sample;
                    r_total <= r_total - TW'(r_old) + TW'(r_sample);
                    r_pos   <= (r_pos == LAST) ? '0 : r_pos + 1'b1;
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_x     <= XW'(r_total);
                    r_prod  <= '0;
                    r_mcnt  <= 3'(NCH);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= (r_prod << 16) + PRW'(part);
                    r_x    <= r_x << 16;
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == 3'd1) r_state <= S_MEAN;
                end
                S_MEAN: begin
                    r_minute <= r_prod[TW+LW +: 40];
                    r_upd    <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_word.hash_total      <= r_accum;
                        o_word.rate_now        <= r_rate;
                        o_word.rate_minute     <= r_minute;
                        o_word.shares_accepted <= r_acc;
                        o_word.shares_rejected <= r_rej;
                        o_word.blocks_found    <= i_blocks_seed + r_blk;
                        o_word.session_best    <= r_best;
                        o_word.overall_best    <= (i_best_seed > r_best) ? i_best_seed : r_best;
                        o_word.last_share_ms   <= r_stamp;
                        o_word.rate_updated    <= r_upd;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
